// File: rtl/pfs_pkg.sv
// Shared types and constants for the PPM frame sequencer.
package pfs_pkg;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_SLOT    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [1:0] CFG_ACTIVE   = 2'd0;
  localparam logic [1:0] CFG_MIN_SYNC = 2'd1;

  localparam logic [15:0] SYNC_EXTRA     = 16'd300;
  localparam logic [4:0]  RESET_SLOT     = 5'd16;
  localparam logic [4:0]  RESET_ACTIVE   = 5'd16;
  localparam logic [15:0] RESET_MIN_SYNC = 16'd3000;
  localparam logic [15:0] RESET_SYNC     = RESET_MIN_SYNC + SYNC_EXTRA;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  channel;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] period;
    logic        is_sync;
    logic [4:0]  slot;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  active_channels;
    logic [15:0] min_sync;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SLOT,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  channel;
    logic [15:0] value;
  } cmd_t;

  // Handshake between queue and its neighbours.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// File: rtl/pfs_front.sv
// Input stage: takes items and turns them into queued commands.
module pfs_front import pfs_pkg::*; (
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      push_cmd
);

  logic known;

  always_comb begin
    known          = 1'b1;
    push_cmd.op    = OP_WRITE;
    push_cmd.channel = in_item.channel;
    push_cmd.value   = in_item.value;
    unique case (in_item.func)
      FUNC_WRITE:   push_cmd.op = OP_WRITE;
      FUNC_SLOT:    push_cmd.op = OP_SLOT;
      FUNC_RESTART: push_cmd.op = OP_RESTART;
      default:      known = 1'b0;  // unused code, dropped
    endcase
  end

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full && known && !rst;

endmodule

// File: rtl/pfs_queue.sv
// Two-entry command queue between the front and back stages.
module pfs_queue import pfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/pfs_back.sv
// Execution stage: channel table, slot and sync state, output register.
module pfs_back import pfs_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  cmd_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [5:0] CH_LIMIT = 6'(NUM_CHANNELS);

  logic [15:0] periods [NUM_CHANNELS];
  logic [4:0]  slot_index;
  logic [15:0] sync_remaining;

  logic [4:0]  count_eff;
  logic        is_chan;
  logic [15:0] rd_period;
  logic [15:0] diff;
  logic [15:0] sync_sub;
  logic [4:0]  ch5;
  logic        wr_ok;

  always_comb begin
    count_eff = ({1'b0, cfg.active_channels} > CH_LIMIT) ? CH_LIMIT[4:0]
                                                          : cfg.active_channels;
    is_chan   = slot_index < count_eff;
    rd_period = periods[slot_index[IDX_W-1:0]];
    diff      = sync_remaining - rd_period;            // wraps mod 2^16
    sync_sub  = (diff < cfg.min_sync) ? cfg.min_sync : diff;
    ch5       = {1'b0, head.channel};
    wr_ok     = {1'b0, ch5} < CH_LIMIT;
  end

  // Output register frees as soon as downstream takes it.
  assign pop = q_status.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index     <= RESET_SLOT;
      sync_remaining <= RESET_SYNC;
      out_valid      <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        periods[i] <= '0;
      end
    end else begin
      if (pop && head.op == OP_SLOT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (head.op)
          OP_WRITE: begin
            if (wr_ok) begin
              periods[ch5[IDX_W-1:0]] <= head.value;
            end
          end
          OP_RESTART: begin
            slot_index     <= count_eff;
            sync_remaining <= cfg.min_sync + SYNC_EXTRA;
          end
          OP_SLOT: begin
            if (is_chan) begin
              sync_remaining   <= sync_sub;
              slot_index       <= slot_index + 1'b1;
              out_item.period  <= rd_period;
              out_item.is_sync <= 1'b0;
              out_item.slot    <= slot_index;
            end else begin
              slot_index       <= '0;
              out_item.period  <= sync_remaining;
              out_item.is_sync <= 1'b1;
              out_item.slot    <= count_eff;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/ppm_frame_sequencer_top.sv
// Top level of the PPM frame sequencer: config registers and stage wiring.
//
// Use: in_item carries func/channel/value. A write stores a channel period,
// a restart parks the slot index at the active count and reloads the sync
// gap to min_sync + 300, and a slot event yields one out_item: the next
// channel's period (sync gap shrinks by it, floored at min_sync) or, after
// the last active channel, the sync gap itself with slot = active count.
// Writes, restarts and the unused func code give no out_item.
// Channels: in_valid/in_stall and out_valid/out_stall; an item moves when
// valid is high and stall low. cfg_valid/cfg_ready writes register
// cfg_index (0 active_channels, 1 min_sync); cfg_ready is always high and
// writes are expected only while the block is idle.
// An accepted item passes the queue write, then the back stage's output
// register, before out_valid rises. Throughput: one item per cycle while
// not stalled, set by the back stage's combinational read/subtract/clamp.
// Receiver stall: out_item holds; the back stage stops popping the 2-entry
// queue and in_stall rises once the queue is full.
// Reset (rst, synchronous): periods zero, slot index 16, sync 3300,
// active_channels 16, min_sync 3000, queue empty, no result pending.
module ppm_frame_sequencer_top import pfs_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t cfg;
  logic      q_push;
  logic      q_pop;
  cmd_t      q_in;
  cmd_t      q_head;
  q_status_t q_status;

  assign cfg_ready = 1'b1;

  // Config registers; indices past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_channels <= RESET_ACTIVE;
      cfg.min_sync        <= RESET_MIN_SYNC;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE:   cfg.active_channels <= cfg_data[4:0];
        CFG_MIN_SYNC: cfg.min_sync <= cfg_data;
        default: ;
      endcase
    end
  end

  pfs_front u_front (
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (q_push),
    .push_cmd (q_in)
  );

  pfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  pfs_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (q_head),
    .q_status  (q_status),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // No push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("push into full queue");

  // Pop only from a non-empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.valid)
    else $error("pop from empty queue");

  // A channel slot always names a channel that exists.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.is_sync) |-> ({1'b0, out_item.slot} < 6'(NUM_CHANNELS)))
    else $error("channel slot out of range");

  // Nothing is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result presented straight after reset");

endmodule

// File: tb/sv/pfs_checker.sv
// Checker for the PPM frame sequencer: slot prediction and result comparison.
`timescale 1ns / 100ps

module pfs_checker import pfs_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  // predicted frame state
  logic [15:0] chan_period [NUM_CHANNELS];
  logic [4:0]  slot_pos;
  logic [15:0] sync_gap;
  logic [4:0]  active_cnt;
  logic [15:0] sync_floor;

  out_item_t due_slots [$];

  task automatic note_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_frame();
    foreach (chan_period[i]) chan_period[i] = '0;
    slot_pos   = RESET_SLOT;
    sync_gap   = RESET_SYNC;
    active_cnt = RESET_ACTIVE;
    sync_floor = RESET_MIN_SYNC;
  endtask

  // Applies one accepted item; returns 1 when a slot result is due.
  function automatic bit advance_frame(input in_item_t it, output out_item_t res);
    logic [5:0]  eff;
    logic [15:0] gap;
    res = '0;
    eff = (active_cnt > NUM_CHANNELS) ? 6'(NUM_CHANNELS) : 6'(active_cnt);
    case (it.func)
      FUNC_WRITE: begin
        if (it.channel < NUM_CHANNELS) chan_period[it.channel] = it.value;
        return 0;
      end
      FUNC_RESTART: begin
        slot_pos = eff[4:0];
        sync_gap = sync_floor + SYNC_EXTRA;
        return 0;
      end
      FUNC_SLOT: begin
        if (6'(slot_pos) < eff) begin
          res.period  = chan_period[slot_pos];
          res.is_sync = 1'b0;
          res.slot    = slot_pos;
          gap = sync_gap - res.period;   // wraps at 16 bits
          sync_gap = (gap < sync_floor) ? sync_floor : gap;
          slot_pos = slot_pos + 5'd1;
        end else begin
          res.period  = sync_gap;
          res.is_sync = 1'b1;
          res.slot    = eff[4:0];
          slot_pos    = '0;
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst) begin
      clear_frame();
      due_slots.delete();
    end else begin
      // a result never leaves in the same cycle as its item, so check first
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_slots.size() == 0) begin
          note_mismatch($sformatf("unexpected result period=%h is_sync=%b slot=%0d",
                                  out_item.period, out_item.is_sync, out_item.slot));
        end else begin
          want = due_slots.pop_front();
          if (out_item.period !== want.period)
            note_mismatch($sformatf("period %h, expected %h", out_item.period, want.period));
          if (out_item.is_sync !== want.is_sync)
            note_mismatch($sformatf("is_sync %b, expected %b", out_item.is_sync,
                                    want.is_sync));
          if (out_item.slot !== want.slot)
            note_mismatch($sformatf("slot %0d, expected %0d", out_item.slot, want.slot));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACTIVE:   active_cnt = cfg_data[4:0];
          CFG_MIN_SYNC: sync_floor = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (advance_frame(in_item, got)) due_slots.push_back(got);
      end
    end
    pending = due_slots.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the PPM frame sequencer: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb import pfs_pkg::*;;

  // func code with no meaning; the block must ignore it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 225;
  localparam int         CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ACTIVE;
  logic [15:0] cfg_data = '0;

  int  fail_count;
  int  pending;
  int  results_seen;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;   // set for the closing phase: no idling on either side

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ppm_frame_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker sees the same three channels as the block and keeps its own
  // copy of the frame state; it only hands back counts.
  pfs_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver side: stall in bursts of random length, changing on the falling
  // edge. Long runs with no stall fall between bursts.
  always begin
    @(negedge clk);
    if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    out_stall = 1'b0;
  end

  // Offers one item and holds it until accepted. Valid stays high after the
  // accepting edge, so a back-to-back item just swaps the payload; a gap
  // drops valid on a falling edge of its own.
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drops valid and waits until every predicted slot has come out, then lets
  // writes and restarts that leave no result behind drain out of the queue.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly slot events and channel writes, so frames run right through; a
  // few restarts break frames early and the odd unused code is noise.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       kind;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    it.channel = 4'($urandom_range(0, 15));
    // periods near typical servo pulses, with the odd extreme or wild value
    if (kind == 0)      it.value = 16'hFFFF;
    else if (kind == 1) it.value = 16'h0000;
    else if (kind < 4)  it.value = 16'($urandom);
    else                it.value = 16'($urandom_range(900, 2100));
    if (pick < 55)      it.func = FUNC_SLOT;
    else if (pick < 85) it.func = FUNC_WRITE;
    else if (pick < 93) it.func = FUNC_RESTART;
    else                it.func = FUNC_UNUSED;
    return it;
  endfunction

  initial begin : stimulus
    logic [4:0]  set_active [PHASES];
    logic [15:0] set_floor  [PHASES];
    // fixed extremes first: single channel with zero floor, counts above and
    // at zero, eight channels, the sixteen-channel limit, and floors that wrap the restart sum
    set_active[0] = 5'd1;  set_floor[0] = 16'd0;
    set_active[1] = 5'd31; set_floor[1] = 16'hFFFF;
    set_active[2] = 5'd0;  set_floor[2] = 16'd1234;
    set_active[3] = 5'd8;  set_floor[3] = 16'd3000;
    set_active[4] = 5'd16; set_floor[4] = 16'hFF00;
    for (int p = 5; p < PHASES; p++) begin
      set_active[p] = 5'($urandom_range(0, 31));
      set_floor[p]  = 16'($urandom_range(0, 6000));
    end

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, extreme periods and channels, every func.
    send_item('{FUNC_WRITE,   4'd0,  16'hFFFF});
    send_item('{FUNC_WRITE,   4'd1,  16'd1000});
    send_item('{FUNC_WRITE,   4'd15, 16'h0000});
    send_item('{FUNC_WRITE,   4'd7,  16'hAAAA});
    send_item('{FUNC_UNUSED,  4'd15, 16'hFFFF});
    send_item('{FUNC_SLOT,    4'd0,  16'h0000});   // slot index starts past the end: sync
    send_item('{FUNC_SLOT,    4'd0,  16'h0000});   // huge period wraps the sync gap
    send_item('{FUNC_SLOT,    4'd0,  16'h0000});   // gap clamped up to the floor
    send_item('{FUNC_RESTART, 4'd0,  16'h0000});
    send_item('{FUNC_SLOT,    4'd5,  16'h5555});   // sync straight after restart
    send_item('{FUNC_WRITE,   4'd2,  16'h5555});
    send_item('{FUNC_WRITE,   4'd8,  16'h0001});
    for (int k = 0; k < 12; k++) send_item('{FUNC_SLOT, 4'd0, 16'h0000});

    // Random phases, each behind a register change made while idle.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_ACTIVE, {11'd0, set_active[p]});
      write_reg(CFG_MIN_SYNC, set_floor[p]);
      if (p == PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
    end

    settle();
    repeat (8) @(negedge clk);

    $display("Ran %0d items over %0d register settings (active count 0 to 31,",
             items_sent, PHASES + 1);
    $display("sync floor 0 to 65535); %0d slot results compared.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: ppm_frame_sequencer_top.f
rtl/pfs_pkg.sv
rtl/pfs_front.sv
rtl/pfs_queue.sv
rtl/pfs_back.sv
rtl/ppm_frame_sequencer_top.sv
tb/sv/pfs_checker.sv
tb/sv/tb.sv
